### design/svpid_pkg.sv
package svpid_pkg;

   localparam int NUM_SERVOS_DEF = 12;

   localparam int POS_W    = 7;
   localparam int CSR_W    = 16;
   localparam int PERIOD_W = 16;
   localparam int DIVR_W   = 10;
   localparam int DMAG_W   = 16;
   localparam int ACC_W    = 34;
   localparam int PC_W     = 4;
   localparam int CNT_W    = 4;

   localparam int GAIN_P_Q12   = 1065;
   localparam int GAIN_I_Q12   = 61;
   localparam int GAIN_D_Q12   = 164;
   localparam int POS_MAX      = 97;
   localparam int POS_MIN      = 1;
   localparam int CMD_BASE     = 144;
   localparam int POS_RESET    = 64;
   localparam int PERIOD_RESET = 100;
   localparam int DIV_RECIP    = 83887;
   localparam int DIV_SHIFT    = 23;
   localparam int DIV_STEPS    = 16;

   typedef enum logic [1:0] {
      REQ_COMMAND  = 2'd0,
      REQ_DEFAULTS = 2'd1,
      REQ_RESTART  = 2'd2
   } svpid_req_code_type;

   typedef enum logic [1:0] {
      CSR_PID_ENABLE  = 2'd0,
      CSR_DEFAULT_POS = 2'd1,
      CSR_PERIOD      = 2'd2
   } svpid_csr_index_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic [3:0] servo_number;
      logic [6:0] target;
   } svpid_req_type;

   typedef struct packed {
      logic [7:0] cmd_byte;
      logic [6:0] value;
      logic       last;
   } svpid_rsp_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_PASS,
      OP_DEFAULT,
      OP_RESTART,
      OP_ERR,
      OP_PTERM,
      OP_DSETUP,
      OP_INTEG,
      OP_ADDI,
      OP_DIVSTEP,
      OP_ADDD,
      OP_POSOUT
   } svpid_op_type;

   typedef enum logic [1:0] {
      BR_NEXT,
      BR_DONE,
      BR_LOOP_CH,
      BR_LOOP_DIV
   } svpid_br_type;

   typedef logic [PC_W-1:0] svpid_pc_type;

   typedef struct packed {
      svpid_op_type op;
      svpid_br_type br;
      svpid_pc_type target;
   } svpid_uinstr_type;

   typedef struct packed {
      logic         load;
      svpid_op_type op;
   } svpid_ctrl_type;

   typedef struct packed {
      logic ch_last;
      logic div_last;
   } svpid_status_type;

   localparam svpid_pc_type PC_IGNORE   = 4'd0;
   localparam svpid_pc_type PC_PASS     = 4'd1;
   localparam svpid_pc_type PC_DEFAULTS = 4'd2;
   localparam svpid_pc_type PC_RESTART  = 4'd3;
   localparam svpid_pc_type PC_PID      = 4'd4;
   localparam svpid_pc_type PC_DIV      = 4'd9;

   function automatic svpid_uinstr_type ucode(input svpid_pc_type pc);
      svpid_uinstr_type u;
      case (pc)
         4'd0:    u = '{op: OP_NONE,    br: BR_DONE,     target: PC_IGNORE};
         4'd1:    u = '{op: OP_PASS,    br: BR_DONE,     target: PC_IGNORE};
         4'd2:    u = '{op: OP_DEFAULT, br: BR_LOOP_CH,  target: PC_DEFAULTS};
         4'd3:    u = '{op: OP_RESTART, br: BR_LOOP_CH,  target: PC_RESTART};
         4'd4:    u = '{op: OP_ERR,     br: BR_NEXT,     target: PC_IGNORE};
         4'd5:    u = '{op: OP_PTERM,   br: BR_NEXT,     target: PC_IGNORE};
         4'd6:    u = '{op: OP_DSETUP,  br: BR_NEXT,     target: PC_IGNORE};
         4'd7:    u = '{op: OP_INTEG,   br: BR_NEXT,     target: PC_IGNORE};
         4'd8:    u = '{op: OP_ADDI,    br: BR_NEXT,     target: PC_IGNORE};
         4'd9:    u = '{op: OP_DIVSTEP, br: BR_LOOP_DIV, target: PC_DIV};
         4'd10:   u = '{op: OP_ADDD,    br: BR_NEXT,     target: PC_IGNORE};
         4'd11:   u = '{op: OP_POSOUT,  br: BR_DONE,     target: PC_IGNORE};
         default: u = '{op: OP_NONE,    br: BR_DONE,     target: PC_IGNORE};
      endcase
      return u;
   endfunction

endpackage

### design/servo_pid_channel_updater.sv
// A command runs the PID step when PID is on and passes the target through when it is off;
// defaults give one result a cycle, one per servo; restart resets every servo with no result.
// The PID step is set by the microprogram: five setup steps, a 16-step divide loop, two to finish.
// busy drops in the cycle the final result, if any, is shown; a new request is taken then.
// Synchronous reset restores CSRs and sequencer, positions to 64, errors and integrals to zero.
// Results are strobed for one cycle; the receiver cannot stall.
module servo_pid_channel_updater #(
   parameter int NUM_SERVOS = svpid_pkg::NUM_SERVOS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  svpid_pkg::svpid_req_type           req_item,
   output logic                              rsp_valid,
   output svpid_pkg::svpid_rsp_type           rsp_item,
   input  logic                              csr_wr_en,
   input  logic [1:0]                        csr_index,
   input  logic [svpid_pkg::CSR_W-1:0]       csr_wdata
);

   logic                               pid_en_ff, pid_en_in;
   logic [svpid_pkg::POS_W-1:0]        defpos_ff, defpos_in;
   logic [svpid_pkg::PERIOD_W-1:0]     period_ff, period_in;
   svpid_pkg::svpid_ctrl_type           ctrl;
   svpid_pkg::svpid_status_type         status;

   always_comb begin
      pid_en_in = pid_en_ff;
      defpos_in = defpos_ff;
      period_in = period_ff;
      if (csr_wr_en) begin
         case (csr_index)
            svpid_pkg::CSR_PID_ENABLE:  pid_en_in = csr_wdata[0];
            svpid_pkg::CSR_DEFAULT_POS: defpos_in = csr_wdata[svpid_pkg::POS_W-1:0];
            svpid_pkg::CSR_PERIOD:      period_in = csr_wdata[svpid_pkg::PERIOD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pid_en_ff <= 1'b1;
         defpos_ff <= svpid_pkg::POS_W'(svpid_pkg::POS_RESET);
         period_ff <= svpid_pkg::PERIOD_W'(svpid_pkg::PERIOD_RESET);
      end else begin
         pid_en_ff <= pid_en_in;
         defpos_ff <= defpos_in;
         period_ff <= period_in;
      end
   end

   svpid_sequencer #(
      .NUM_SERVOS(NUM_SERVOS)
   ) u_sequencer (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_item   (req_item),
      .pid_enable (pid_en_ff),
      .status     (status),
      .busy       (busy),
      .ctrl       (ctrl)
   );

   svpid_datapath #(
      .NUM_SERVOS(NUM_SERVOS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .req_item         (req_item),
      .default_position (defpos_ff),
      .output_period    (period_ff),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_item         (rsp_item)
   );

`ifndef SYNTH
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request taken but busy not raised");

   a_rsp_in_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result with no request in progress");

   a_last_ends_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.last == !busy))
      else $error("last flag out of step with end of request");
`endif

endmodule

### design/svpid_sequencer.sv
module svpid_sequencer #(
   parameter int NUM_SERVOS = svpid_pkg::NUM_SERVOS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  svpid_pkg::svpid_req_type    req_item,
   input  logic                       pid_enable,
   input  svpid_pkg::svpid_status_type status,
   output logic                       busy,
   output svpid_pkg::svpid_ctrl_type   ctrl
);

   logic                       busy_ff, busy_in;
   svpid_pkg::svpid_pc_type    pc_ff, pc_in;
   svpid_pkg::svpid_pc_type    entry;
   svpid_pkg::svpid_uinstr_type uinstr;
   logic                       accept;
   logic                       num_ok;

   always_comb begin
      uinstr = svpid_pkg::ucode(pc_ff);
      accept = start & ~busy_ff;
      num_ok = (6'(req_item.servo_number) >= 6'd1) &&
               (6'(req_item.servo_number) <= 6'(NUM_SERVOS));
      case (req_item.req_type)
         svpid_pkg::REQ_COMMAND: begin
            if (!num_ok) begin
               entry = svpid_pkg::PC_IGNORE;
            end else if (pid_enable) begin
               entry = svpid_pkg::PC_PID;
            end else begin
               entry = svpid_pkg::PC_PASS;
            end
         end
         svpid_pkg::REQ_DEFAULTS: entry = svpid_pkg::PC_DEFAULTS;
         svpid_pkg::REQ_RESTART:  entry = svpid_pkg::PC_RESTART;
         default:                 entry = svpid_pkg::PC_IGNORE;
      endcase

      busy_in = busy_ff;
      pc_in   = pc_ff;
      if (accept) begin
         busy_in = 1'b1;
         pc_in   = entry;
      end else if (busy_ff) begin
         case (uinstr.br)
            svpid_pkg::BR_NEXT: pc_in = pc_ff + 1'b1;
            svpid_pkg::BR_DONE: busy_in = 1'b0;
            svpid_pkg::BR_LOOP_CH: begin
               if (status.ch_last) begin
                  busy_in = 1'b0;
               end else begin
                  pc_in = uinstr.target;
               end
            end
            svpid_pkg::BR_LOOP_DIV: begin
               if (status.div_last) begin
                  pc_in = pc_ff + 1'b1;
               end else begin
                  pc_in = uinstr.target;
               end
            end
            default: busy_in = 1'b0;
         endcase
      end

      ctrl.load = accept;
      ctrl.op   = busy_ff ? uinstr.op : svpid_pkg::OP_NONE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= svpid_pkg::PC_IGNORE;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
      end
   end

   assign busy = busy_ff;

endmodule

### design/svpid_datapath.sv
module svpid_datapath #(
   parameter int NUM_SERVOS = svpid_pkg::NUM_SERVOS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  svpid_pkg::svpid_ctrl_type          ctrl,
   input  svpid_pkg::svpid_req_type           req_item,
   input  logic [svpid_pkg::POS_W-1:0]       default_position,
   input  logic [svpid_pkg::PERIOD_W-1:0]    output_period,
   output svpid_pkg::svpid_status_type        status,
   output logic                              rsp_valid,
   output svpid_pkg::svpid_rsp_type           rsp_item
);

   localparam int CHW   = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;
   localparam int POS_W = svpid_pkg::POS_W;
   localparam int ACC_W = svpid_pkg::ACC_W;
   localparam int DVR_W = svpid_pkg::DIVR_W;
   localparam int DMG_W = svpid_pkg::DMAG_W;
   localparam int CNT_W = svpid_pkg::CNT_W;

   logic        [POS_W-1:0] pos_ff   [NUM_SERVOS];
   logic signed [8:0]       perr_ff  [NUM_SERVOS];
   logic signed [31:0]      integ_ff [NUM_SERVOS];

   logic        [CHW-1:0]   ch_ff, ch_in;
   logic        [POS_W-1:0] tgt_ff, tgt_in;
   logic signed [8:0]       err_ff, err_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic        [DVR_W-1:0] dvsr_ff, dvsr_in;
   logic        [DVR_W-1:0] rem_ff, rem_in;
   logic        [DMG_W-1:0] quo_ff, quo_in;
   logic                    neg_ff, neg_in;
   logic        [CNT_W-1:0] cnt_ff, cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   svpid_pkg::svpid_rsp_type rsp_item_ff, rsp_item_in;

   logic                    pos_we, perr_we, integ_we;
   logic                    all_we, all_clear_integ;
   logic        [POS_W-1:0] pos_wd;
   logic signed [8:0]       perr_wd;
   logic signed [31:0]      integ_wd;

   logic        [5:0]       num_m1;
   logic        [POS_W-1:0] pos_rd;
   logic signed [8:0]       perr_rd;
   logic signed [31:0]      integ_rd;
   logic signed [20:0]      p_term;
   logic        [32:0]      recip_prod;
   logic        [DVR_W-1:0] quot100;
   logic signed [9:0]       delta;
   logic signed [18:0]      dnum;
   logic signed [15:0]      ierr;
   logic signed [32:0]      isum;
   logic        [DVR_W:0]   rem_sh;
   logic                    rem_ge;
   logic signed [DMG_W:0]   quo_s;
   logic signed [DMG_W:0]   dval;
   logic        [ACC_W-13:0] whole;
   logic        [POS_W-1:0] pos_new;
   logic        [7:0]       cmd_base;
   logic                    ch_last;

   always_comb begin
      num_m1   = 6'(req_item.servo_number) - 6'd1;
      pos_rd   = pos_ff[ch_ff];
      perr_rd  = perr_ff[ch_ff];
      integ_rd = integ_ff[ch_ff];
      ch_last  = (ch_ff == CHW'(NUM_SERVOS - 1));
      cmd_base = 8'(svpid_pkg::CMD_BASE) + 8'(ch_ff);

      p_term     = 21'(err_ff) * 21'sd1065;
      recip_prod = 33'(output_period) * 33'(svpid_pkg::DIV_RECIP);
      quot100    = recip_prod[svpid_pkg::DIV_SHIFT +: DVR_W];
      delta      = 10'(err_ff) - 10'(perr_rd);
      dnum       = 19'(delta) * 19'sd164;
      ierr       = 16'(err_ff) * 16'sd61;
      isum       = 33'(integ_rd) + 33'(ierr);
      rem_sh     = {rem_ff, quo_ff[DMG_W-1]};
      rem_ge     = (rem_sh >= {1'b0, dvsr_ff});
      quo_s      = $signed({1'b0, quo_ff});
      dval       = neg_ff ? -quo_s : quo_s;
      whole      = acc_ff[ACC_W-1:12];
      if (acc_ff < 34'sd4096) begin
         pos_new = POS_W'(svpid_pkg::POS_MIN);
      end else if (whole > (ACC_W-12)'(svpid_pkg::POS_MAX)) begin
         pos_new = POS_W'(svpid_pkg::POS_MAX);
      end else begin
         pos_new = whole[POS_W-1:0];
      end

      ch_in        = ch_ff;
      tgt_in       = tgt_ff;
      err_in       = err_ff;
      acc_in       = acc_ff;
      dvsr_in      = dvsr_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      neg_in       = neg_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = 1'b0;
      rsp_item_in  = rsp_item_ff;
      pos_we          = 1'b0;
      perr_we         = 1'b0;
      integ_we        = 1'b0;
      all_we          = 1'b0;
      all_clear_integ = 1'b0;
      pos_wd   = default_position;
      perr_wd  = err_ff;
      integ_wd = integ_rd;

      if (ctrl.load) begin
         tgt_in = req_item.target;
         if (req_item.req_type == svpid_pkg::REQ_COMMAND) begin
            ch_in = num_m1[CHW-1:0];
         end else begin
            ch_in = '0;
         end
      end

      case (ctrl.op)
         svpid_pkg::OP_NONE: begin
         end
         svpid_pkg::OP_PASS: begin
            pos_we       = 1'b1;
            pos_wd       = tgt_ff;
            rsp_valid_in = 1'b1;
            rsp_item_in  = '{cmd_byte: cmd_base + 8'd1, value: tgt_ff, last: 1'b1};
         end
         svpid_pkg::OP_DEFAULT: begin
            pos_we       = 1'b1;
            perr_we      = 1'b1;
            pos_wd       = default_position;
            perr_wd      = '0;
            rsp_valid_in = 1'b1;
            rsp_item_in  = '{cmd_byte: cmd_base, value: default_position, last: ch_last};
            ch_in        = ch_ff + 1'b1;
         end
         svpid_pkg::OP_RESTART: begin
            pos_we   = 1'b1;
            perr_we  = 1'b1;
            integ_we = 1'b1;
            pos_wd   = default_position;
            perr_wd  = '0;
            integ_wd = '0;
            ch_in    = ch_ff + 1'b1;
         end
         svpid_pkg::OP_ERR: begin
            err_in = $signed({2'b00, tgt_ff}) - $signed({2'b00, pos_rd});
         end
         svpid_pkg::OP_PTERM: begin
            acc_in  = ACC_W'(p_term) + $signed({15'd0, pos_rd, 12'd0});
            dvsr_in = (quot100 == '0) ? DVR_W'(1) : quot100;
         end
         svpid_pkg::OP_DSETUP: begin
            neg_in  = dnum[18];
            quo_in  = dnum[18] ? DMG_W'(-dnum) : DMG_W'(dnum);
            rem_in  = '0;
            cnt_in  = CNT_W'(svpid_pkg::DIV_STEPS - 1);
            perr_we = 1'b1;
            perr_wd = err_ff;
         end
         svpid_pkg::OP_INTEG: begin
            integ_we = 1'b1;
            if (isum[32] != isum[31]) begin
               integ_wd = isum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
            end else begin
               integ_wd = isum[31:0];
            end
         end
         svpid_pkg::OP_ADDI: begin
            acc_in = acc_ff + ACC_W'(integ_rd);
         end
         svpid_pkg::OP_DIVSTEP: begin
            rem_in = rem_ge ? DVR_W'(rem_sh - {1'b0, dvsr_ff}) : rem_sh[DVR_W-1:0];
            quo_in = {quo_ff[DMG_W-2:0], rem_ge};
            cnt_in = cnt_ff - 1'b1;
         end
         svpid_pkg::OP_ADDD: begin
            acc_in = acc_ff + ACC_W'(dval);
         end
         svpid_pkg::OP_POSOUT: begin
            pos_we       = 1'b1;
            pos_wd       = pos_new;
            rsp_valid_in = 1'b1;
            rsp_item_in  = '{cmd_byte: cmd_base + 8'd1, value: pos_new, last: 1'b1};
         end
         default: begin
         end
      endcase

      status.ch_last  = ch_last;
      status.div_last = (cnt_ff == '0);
   end

   always_ff @(posedge clock) begin
      ch_ff       <= ch_in;
      tgt_ff      <= tgt_in;
      err_ff      <= err_in;
      acc_ff      <= acc_in;
      dvsr_ff     <= dvsr_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      neg_ff      <= neg_in;
      cnt_ff      <= cnt_in;
      rsp_item_ff <= rsp_item_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_SERVOS; i++) begin
            pos_ff[i]   <= POS_W'(svpid_pkg::POS_RESET);
            perr_ff[i]  <= '0;
            integ_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pos_we) begin
            pos_ff[ch_ff] <= pos_wd;
         end
         if (perr_we) begin
            perr_ff[ch_ff] <= perr_wd;
         end
         if (integ_we) begin
            integ_ff[ch_ff] <= integ_wd;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule
